FILE: design/wta_pkg.sv
`timescale 1ns / 1ps
package wta_pkg;
   localparam int MAX_BINS_DEF    = 1024;
   localparam int MAX_THREADS_DEF = 4;
   localparam int MAX_DIMS_DEF    = 4;

   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int TID_W  = 2;
   localparam int VAL_W  = 32;
   localparam int WGT_W  = 32;
   localparam int VSUM_W = 64;
   localparam int WSUM_W = 48;
   localparam int HIT_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_REDUCED = 2'd1,
      ST_BAD_IDX = 2'd2,
      ST_ZERO_WT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_DIMS    = 3'd0,
      REG_BINS0   = 3'd1,
      REG_BINS1   = 3'd2,
      REG_BINS2   = 3'd3,
      REG_BINS3   = 3'd4,
      REG_SIZE    = 3'd5,
      REG_SHARED  = 3'd6,
      REG_REDUCED = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      BK_CLEAR, BK_IDLE, BK_READ, BK_WRITE
   } back_state_type;

   // classified word handed from front to back
   typedef struct packed {
      status_type         status;
      logic [IDX_W-1:0]   flat;
      logic [TID_W-1:0]   seg;
      logic               neg;
      logic [VAL_W-1:0]   mag;
      logic [WGT_W-1:0]   weight;
   } cmd_type;
endpackage

FILE: design/wta_front.sv
`timescale 1ns / 1ps
module wta_front #(
   parameter int MAX_BINS    = wta_pkg::MAX_BINS_DEF,
   parameter int MAX_THREADS = wta_pkg::MAX_THREADS_DEF,
   parameter int MAX_DIMS    = wta_pkg::MAX_DIMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [wta_pkg::VAL_W-1:0]     sample_value,
   input  logic [wta_pkg::WGT_W-1:0]     sample_weight,
   input  logic [wta_pkg::TID_W-1:0]     thread_id,
   input  logic                          use_direct,
   input  logic [wta_pkg::IDX_W-1:0]     flat_index_in,
   input  logic [wta_pkg::IDX_W-1:0]     bin_index0,
   input  logic [wta_pkg::IDX_W-1:0]     bin_index1,
   input  logic [wta_pkg::IDX_W-1:0]     bin_index2,
   input  logic [wta_pkg::IDX_W-1:0]     bin_index3,
   input  logic [2:0]                    dims_used,
   input  logic [wta_pkg::CNT_W-1:0]     bins_dim0,
   input  logic [wta_pkg::CNT_W-1:0]     bins_dim1,
   input  logic [wta_pkg::CNT_W-1:0]     bins_dim2,
   input  logic [wta_pkg::CNT_W-1:0]     bins_dim3,
   input  logic [wta_pkg::CNT_W-1:0]     tally_size,
   input  logic                          shared_buffer,
   input  logic                          buffer_reduced,
   output logic                          out_valid,
   input  logic                          out_ready,
   output wta_pkg::cmd_type              out_cmd
);
   // Sequential mixed-radix combine: one dimension per cycle.
   // flat and radix are capped so they stay narrow (anything >usable is bad anyway);
   // their low index bits are kept exactly, mod 2^IDX_W, for the reported flat index.
   localparam int LIM = (MAX_DIMS < 4) ? MAX_DIMS : 4;
   localparam int AW  = 22; // holds 1024*1024*... capped below

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [1:0]               dim_ff, dim_in;
   logic [1:0]               last_ff, last_in;
   logic                     bad_ff, bad_in;
   logic [AW-1:0]            flat_ff, flat_in;
   logic [AW-1:0]            radix_ff, radix_in;
   logic [wta_pkg::IDX_W-1:0] flat_lo_ff, flat_lo_in;
   logic [wta_pkg::IDX_W-1:0] radix_lo_ff, radix_lo_in;
   logic [wta_pkg::IDX_W-1:0] ix_ff [4];
   logic [wta_pkg::VAL_W-1:0] val_ff;
   logic [wta_pkg::WGT_W-1:0] wgt_ff;
   logic [wta_pkg::TID_W-1:0] tid_ff;
   logic                     direct_ff;
   logic [wta_pkg::CNT_W-1:0] usable;
   logic [wta_pkg::IDX_W-1:0] ix_cur;
   logic [wta_pkg::CNT_W-1:0] nb_cur;
   logic [AW+wta_pkg::CNT_W-1:0] prod_ix, prod_nb;
   logic [2*wta_pkg::IDX_W-1:0] lo_ix;
   logic [wta_pkg::IDX_W+wta_pkg::CNT_W-1:0] lo_nb;
   logic [AW:0]              sum;
   logic                     over_l, bad_w, tid_bad;
   localparam logic [AW-1:0] CAP = AW'(1) << 12; // > any usable size

   assign usable = (tally_size < wta_pkg::CNT_W'(MAX_BINS)) ? tally_size
                                                           : wta_pkg::CNT_W'(MAX_BINS);
   assign in_ready  = !busy_ff;
   assign out_valid = done_ff;

   always_comb begin
      ix_cur = ix_ff[dim_ff];
      unique case (dim_ff)
         2'd0: nb_cur = bins_dim0;
         2'd1: nb_cur = bins_dim1;
         2'd2: nb_cur = bins_dim2;
         default: nb_cur = bins_dim3;
      endcase
      prod_ix = AW'(ix_cur) * radix_ff;
      prod_nb = AW'(nb_cur) * radix_ff;
      lo_ix   = ix_cur * radix_lo_ff;
      lo_nb   = nb_cur * radix_lo_ff;
      sum = {1'b0, flat_ff} + (prod_ix > (AW+wta_pkg::CNT_W)'(CAP) ? {1'b0, CAP}
                                                                 : (AW+1)'(prod_ix));
      busy_in = busy_ff; done_in = done_ff; dim_in = dim_ff; last_in = last_ff;
      bad_in = bad_ff; flat_in = flat_ff; radix_in = radix_ff;
      flat_lo_in = flat_lo_ff; radix_lo_in = radix_lo_ff;
      if (in_valid && !busy_ff) begin
         busy_in = 1'b1; dim_in = 2'd0; bad_in = 1'b0; radix_in = AW'(1);
         flat_in = use_direct ? AW'(flat_index_in) : '0;
         flat_lo_in  = use_direct ? flat_index_in : '0;
         radix_lo_in = wta_pkg::IDX_W'(1);
         done_in = use_direct;
         if (dims_used == 3'd0) last_in = 2'd0;
         else if (dims_used > 3'(LIM)) last_in = 2'(LIM - 1);
         else last_in = 2'(dims_used - 3'd1);
      end else if (busy_ff && !done_ff) begin
         if (AW'(ix_cur) >= AW'(nb_cur)) bad_in = 1'b1;
         flat_in  = (sum > (AW+1)'(CAP)) ? CAP : sum[AW-1:0];
         radix_in = (prod_nb > (AW+wta_pkg::CNT_W)'(CAP)) ? CAP : prod_nb[AW-1:0];
         flat_lo_in  = flat_lo_ff + lo_ix[wta_pkg::IDX_W-1:0];
         radix_lo_in = lo_nb[wta_pkg::IDX_W-1:0];
         dim_in   = dim_ff + 2'd1;
         if (dim_ff == last_ff) done_in = 1'b1;
      end else if (done_ff && out_ready) begin
         busy_in = 1'b0; done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      dim_ff <= dim_in; last_ff <= last_in; bad_ff <= bad_in;
      flat_ff <= flat_in; radix_ff <= radix_in;
      flat_lo_ff <= flat_lo_in; radix_lo_ff <= radix_lo_in;
      if (in_valid && !busy_ff) begin
         ix_ff[0] <= bin_index0; ix_ff[1] <= bin_index1;
         ix_ff[2] <= bin_index2; ix_ff[3] <= bin_index3;
         val_ff <= sample_value; wgt_ff <= sample_weight;
         tid_ff <= thread_id; direct_ff <= use_direct;
      end
   end

   always_comb begin
      over_l  = (flat_ff >= AW'(usable)) || (!direct_ff && radix_ff > AW'(usable));
      tid_bad = !shared_buffer && (32'(tid_ff) >= 32'(MAX_THREADS));
      bad_w   = bad_ff || over_l || tid_bad;
      out_cmd.flat   = flat_lo_ff;
      out_cmd.seg    = shared_buffer ? '0 : tid_ff;
      out_cmd.neg    = val_ff[wta_pkg::VAL_W-1];
      out_cmd.mag    = val_ff[wta_pkg::VAL_W-1] ? (~val_ff + 1'b1) : val_ff;
      out_cmd.weight = wgt_ff;
      priority if (bad_w)                out_cmd.status = wta_pkg::ST_BAD_IDX;
      else if (wgt_ff == '0)             out_cmd.status = wta_pkg::ST_ZERO_WT;
      else if (buffer_reduced)           out_cmd.status = wta_pkg::ST_REDUCED;
      else                               out_cmd.status = wta_pkg::ST_ADDED;
   end
endmodule

FILE: design/wta_queue.sv
`timescale 1ns / 1ps
module wta_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [W-1:0] din,
   input  logic         pop,
   output logic         empty,
   output logic [W-1:0] dout
);
   // two-entry queue
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign dout    = mem_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (do_push) wp_ff <= !wp_ff;
         if (do_pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) mem_ff[wp_ff] <= din;
   end
endmodule

FILE: design/wta_back.sv
`timescale 1ns / 1ps
module wta_back #(
   parameter int MAX_BINS    = wta_pkg::MAX_BINS_DEF,
   parameter int MAX_THREADS = wta_pkg::MAX_THREADS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_take,
   input  wta_pkg::cmd_type               cmd,
   output logic                           rsp_push,
   input  logic                           rsp_full,
   output logic [1:0]                     rsp_status,
   output logic [wta_pkg::IDX_W-1:0]      rsp_flat,
   output logic [wta_pkg::VSUM_W-1:0]     rsp_vsum,
   output logic [wta_pkg::WSUM_W-1:0]     rsp_wsum,
   output logic [wta_pkg::HIT_W-1:0]      rsp_hits
);
   localparam int DEPTH = MAX_BINS * MAX_THREADS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int EW    = wta_pkg::VSUM_W + wta_pkg::WSUM_W + wta_pkg::HIT_W;

   logic [EW-1:0] store [DEPTH];
   logic [EW-1:0] rd_ff;
   wta_pkg::back_state_type st_ff, st_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] addr_ff;
   logic [63:0]   prod_ff;
   wta_pkg::cmd_type cmd_ff;
   logic [AW-1:0] addr_c;
   logic          we;
   logic [EW-1:0] wdata;
   logic signed [wta_pkg::VSUM_W-1:0] s_old, s_new;
   logic signed [wta_pkg::VSUM_W:0]   s_ext;
   logic [wta_pkg::WSUM_W:0] w_ext;
   logic [wta_pkg::WSUM_W-1:0] w_new;
   logic [wta_pkg::HIT_W-1:0] c_new;
   logic [BW+wta_pkg::TID_W:0] aw_full;

   always_comb begin
      aw_full = (BW+wta_pkg::TID_W+1)'(cmd.seg) * (BW+wta_pkg::TID_W+1)'(MAX_BINS)
              + (BW+wta_pkg::TID_W+1)'(cmd.flat);
      addr_c = (32'(aw_full) >= 32'(DEPTH)) ? '0 : AW'(aw_full);
   end

   always_comb begin
      s_old = rd_ff[EW-1 -: wta_pkg::VSUM_W];
      if (cmd_ff.neg) begin
         s_ext = {s_old[63], s_old} - {1'b0, prod_ff};
         s_new = (s_ext[64] != s_ext[63]) ? {1'b1, 63'd0} : s_ext[63:0];
      end else begin
         s_ext = {s_old[63], s_old} + {1'b0, prod_ff};
         s_new = (s_ext[64] != s_ext[63]) ? {1'b0, {63{1'b1}}} : s_ext[63:0];
      end
      w_ext = {1'b0, rd_ff[wta_pkg::HIT_W +: wta_pkg::WSUM_W]} + (wta_pkg::WSUM_W+1)'(cmd_ff.weight);
      w_new = w_ext[wta_pkg::WSUM_W] ? '1 : w_ext[wta_pkg::WSUM_W-1:0];
      c_new = (&rd_ff[wta_pkg::HIT_W-1:0]) ? rd_ff[wta_pkg::HIT_W-1:0]
                                           : rd_ff[wta_pkg::HIT_W-1:0] + 1'b1;
   end

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; cmd_take = 1'b0; rsp_push = 1'b0;
      we = 1'b0; wdata = {s_new, w_new, c_new};
      rsp_status = cmd.status; rsp_flat = cmd.flat;
      rsp_vsum = '0; rsp_wsum = '0; rsp_hits = '0;
      unique case (st_ff)
         wta_pkg::BK_CLEAR: begin
            we = 1'b1; wdata = '0; clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) st_in = wta_pkg::BK_IDLE;
         end
         wta_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.status != wta_pkg::ST_ADDED) begin
                  if (!rsp_full) begin
                     rsp_push = 1'b1; cmd_take = 1'b1;
                  end
               end else begin
                  cmd_take = 1'b1; st_in = wta_pkg::BK_READ;
               end
            end
         end
         wta_pkg::BK_READ: st_in = wta_pkg::BK_WRITE;
         default: begin
            rsp_status = cmd_ff.status; rsp_flat = cmd_ff.flat;
            rsp_vsum = s_new; rsp_wsum = w_new; rsp_hits = c_new;
            if (!rsp_full) begin
               rsp_push = 1'b1; we = 1'b1; st_in = wta_pkg::BK_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= wta_pkg::BK_CLEAR; clr_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in;
      end
      if (cmd_take) begin
         cmd_ff <= cmd; addr_ff <= addr_c;
         prod_ff <= 64'(cmd.mag) * 64'(cmd.weight);
      end
      if (we) store[(st_ff == wta_pkg::BK_CLEAR) ? clr_ff : addr_ff] <= wdata;
      rd_ff <= store[addr_ff];
   end
endmodule

FILE: design/weighted_tally_accumulator.sv
`timescale 1ns / 1ps
// Path: a word is registered in the front, then passes the command queue, the back end and
//   the result queue; rejected words skip the tally memory, and per-dimension addressing adds
//   the serial index combine in the front. The front takes no new word until it has handed
//   on its last; the back does the read / modify / write of the tally memory one word at a time.
// Reset: synchronous; then a clearing pass zeroes all MAX_BINS*MAX_THREADS (4096 by default)
//   tally entries while words wait in front (registers accepted as ever).
module weighted_tally_accumulator #(
   parameter int MAX_BINS    = wta_pkg::MAX_BINS_DEF,
   parameter int MAX_THREADS = wta_pkg::MAX_THREADS_DEF,
   parameter int MAX_DIMS    = wta_pkg::MAX_DIMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [wta_pkg::VAL_W-1:0]          req_sample_value,
   input  logic [wta_pkg::WGT_W-1:0]          req_sample_weight,
   input  logic [wta_pkg::TID_W-1:0]          req_thread_id,
   input  logic                               req_use_direct,
   input  logic [wta_pkg::IDX_W-1:0]          req_flat_index_in,
   input  logic [wta_pkg::IDX_W-1:0]          req_bin_index0,
   input  logic [wta_pkg::IDX_W-1:0]          req_bin_index1,
   input  logic [wta_pkg::IDX_W-1:0]          req_bin_index2,
   input  logic [wta_pkg::IDX_W-1:0]          req_bin_index3,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [1:0]                         rsp_status,
   output logic [wta_pkg::IDX_W-1:0]          rsp_flat_index_out,
   output logic [wta_pkg::VSUM_W-1:0]         rsp_value_sum,
   output logic [wta_pkg::WSUM_W-1:0]         rsp_weight_sum,
   output logic [wta_pkg::HIT_W-1:0]          rsp_hit_count,
   input  logic                               csr_we,
   input  logic [wta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wta_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int RW = 2 + wta_pkg::IDX_W + wta_pkg::VSUM_W + wta_pkg::WSUM_W + wta_pkg::HIT_W;
   localparam int CW = $bits(wta_pkg::cmd_type);

   // config registers
   logic [2:0]                 dims_ff;
   logic [wta_pkg::CNT_W-1:0]  bins0_ff, bins1_ff, bins2_ff, bins3_ff, size_ff;
   logic                       shared_ff, reduced_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 3'd1; bins0_ff <= 11'd1024; bins1_ff <= 11'd1;
         bins2_ff <= 11'd1; bins3_ff <= 11'd1; size_ff <= 11'd1024;
         shared_ff <= 1'b0; reduced_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (wta_pkg::csr_reg_type'(csr_index))
            wta_pkg::REG_DIMS:    dims_ff    <= csr_wdata[2:0];
            wta_pkg::REG_BINS0:   bins0_ff   <= csr_wdata;
            wta_pkg::REG_BINS1:   bins1_ff   <= csr_wdata;
            wta_pkg::REG_BINS2:   bins2_ff   <= csr_wdata;
            wta_pkg::REG_BINS3:   bins3_ff   <= csr_wdata;
            wta_pkg::REG_SIZE:    size_ff    <= csr_wdata;
            wta_pkg::REG_SHARED:  shared_ff  <= csr_wdata[0];
            default:              reduced_ff <= csr_wdata[0];
         endcase
      end
   end

   // front -> queue -> back
   logic             f_valid, f_ready, q_full, q_empty, q_pop;
   wta_pkg::cmd_type f_cmd, b_cmd;
   logic [CW-1:0]    q_dout;
   logic             r_push, r_full;
   logic [1:0]       r_status;
   logic [wta_pkg::IDX_W-1:0]  r_flat;
   logic [wta_pkg::VSUM_W-1:0] r_vsum;
   logic [wta_pkg::WSUM_W-1:0] r_wsum;
   logic [wta_pkg::HIT_W-1:0]  r_hits;
   logic [RW-1:0]    r_dout;

   assign req_full = !f_ready;

   wta_front #(.MAX_BINS(MAX_BINS), .MAX_THREADS(MAX_THREADS), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock, .reset, .in_valid(req_push), .in_ready(f_ready),
      .sample_value(req_sample_value), .sample_weight(req_sample_weight),
      .thread_id(req_thread_id), .use_direct(req_use_direct),
      .flat_index_in(req_flat_index_in), .bin_index0(req_bin_index0),
      .bin_index1(req_bin_index1), .bin_index2(req_bin_index2),
      .bin_index3(req_bin_index3), .dims_used(dims_ff), .bins_dim0(bins0_ff),
      .bins_dim1(bins1_ff), .bins_dim2(bins2_ff), .bins_dim3(bins3_ff),
      .tally_size(size_ff), .shared_buffer(shared_ff), .buffer_reduced(reduced_ff),
      .out_valid(f_valid), .out_ready(!q_full), .out_cmd(f_cmd)
   );

   wta_queue #(.W(CW)) u_cmdq (
      .clock, .reset, .push(f_valid), .full(q_full), .din(f_cmd),
      .pop(q_pop), .empty(q_empty), .dout(q_dout)
   );
   assign b_cmd = wta_pkg::cmd_type'(q_dout);

   wta_back #(.MAX_BINS(MAX_BINS), .MAX_THREADS(MAX_THREADS)) u_back (
      .clock, .reset, .cmd_valid(!q_empty), .cmd_take(q_pop), .cmd(b_cmd),
      .rsp_push(r_push), .rsp_full(r_full), .rsp_status(r_status), .rsp_flat(r_flat),
      .rsp_vsum(r_vsum), .rsp_wsum(r_wsum), .rsp_hits(r_hits)
   );

   // result queue: parts the back end from the consumer
   wta_queue #(.W(RW)) u_rspq (
      .clock, .reset, .push(r_push), .full(r_full),
      .din({r_status, r_flat, r_vsum, r_wsum, r_hits}),
      .pop(rsp_pop), .empty(rsp_empty), .dout(r_dout)
   );
   assign {rsp_status, rsp_flat_index_out, rsp_value_sum, rsp_weight_sum, rsp_hit_count} = r_dout;
endmodule

FILE: verif/weighted_tally_accumulator_tb.sv
`timescale 1ns / 1ps
module weighted_tally_accumulator_tb;
   import wta_pkg::*;

   localparam int BINS       = MAX_BINS_DEF;
   localparam int DEPTH      = MAX_BINS_DEF * MAX_THREADS_DEF;
   localparam int CYCLE_CAP  = 1000000;

   // one scored event as presented on the req_ side
   typedef struct {
      logic [VAL_W-1:0]  value;
      logic [WGT_W-1:0]  weight;
      logic [TID_W-1:0]  tid;
      logic              direct;
      logic [IDX_W-1:0]  flat;
      logic [IDX_W-1:0]  ix [4];
   } tally_event_t;

   // bin contents the block should report for one word
   typedef struct {
      status_type         status;
      logic [IDX_W-1:0]   flat;
      logic [VSUM_W-1:0]  vsum;
      logic [WSUM_W-1:0]  wsum;
      logic [HIT_W-1:0]   hits;
   } bin_report_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [VAL_W-1:0]       req_sample_value = '0;
   logic [WGT_W-1:0]       req_sample_weight = '0;
   logic [TID_W-1:0]       req_thread_id = '0;
   logic                   req_use_direct = 1'b0;
   logic [IDX_W-1:0]       req_flat_index_in = '0;
   logic [IDX_W-1:0]       req_bin_index0 = '0;
   logic [IDX_W-1:0]       req_bin_index1 = '0;
   logic [IDX_W-1:0]       req_bin_index2 = '0;
   logic [IDX_W-1:0]       req_bin_index3 = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [1:0]             rsp_status;
   logic [IDX_W-1:0]       rsp_flat_index_out;
   logic [VSUM_W-1:0]      rsp_value_sum;
   logic [WSUM_W-1:0]      rsp_weight_sum;
   logic [HIT_W-1:0]       rsp_hit_count;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   always #5 clock = ~clock;

   weighted_tally_accumulator u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sample_value(req_sample_value), .req_sample_weight(req_sample_weight),
      .req_thread_id(req_thread_id), .req_use_direct(req_use_direct),
      .req_flat_index_in(req_flat_index_in),
      .req_bin_index0(req_bin_index0), .req_bin_index1(req_bin_index1),
      .req_bin_index2(req_bin_index2), .req_bin_index3(req_bin_index3),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_status(rsp_status),
      .rsp_flat_index_out(rsp_flat_index_out), .rsp_value_sum(rsp_value_sum),
      .rsp_weight_sum(rsp_weight_sum), .rsp_hit_count(rsp_hit_count),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the tally store and of the registers
   logic signed [VSUM_W-1:0] vsum_mem [DEPTH];
   logic [WSUM_W-1:0]        wsum_mem [DEPTH];
   logic [HIT_W-1:0]         hits_mem [DEPTH];
   logic [2:0]               sh_dims;
   logic [CNT_W-1:0]         sh_bins [4];
   logic [CNT_W-1:0]         sh_size;
   logic                     sh_shared;
   logic                     sh_reduced;

   bin_report_t  pending_reports [$];
   int           fail_count = 0;
   int           cycle_count = 0;
   int           pop_hold = 0;

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
   endtask

   // random gap: mostly none or short, now and then long
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // bin address and update, in the block's own order of checks
   function automatic bin_report_t predict_bin(tally_event_t ev);
      bin_report_t          rep;
      logic [63:0]          usable, flat, radix;
      int                   nd;
      logic                 bad, neg;
      logic [31:0]          mag;
      logic [63:0]          prod;
      logic signed [64:0]   wide;
      logic [WSUM_W:0]      wnext;
      int                   addr;
      usable = (sh_size < BINS) ? sh_size : BINS;
      flat   = 0;
      bad    = 1'b0;
      if (ev.direct) begin
         flat = ev.flat;
         if (flat >= usable) bad = 1'b1;
      end else begin
         nd = sh_dims;
         if (nd < 1) nd = 1;
         if (nd > MAX_DIMS_DEF) nd = MAX_DIMS_DEF;
         radix = 1;
         for (int d = 0; d < nd; d++) begin
            if (ev.ix[d] >= sh_bins[d]) bad = 1'b1;
            flat  += ev.ix[d] * radix;
            radix *= sh_bins[d];
         end
         if (flat >= usable || radix > usable) bad = 1'b1;
      end
      rep.flat = flat[IDX_W-1:0];
      rep.vsum = '0;
      rep.wsum = '0;
      rep.hits = '0;
      if (bad)             rep.status = ST_BAD_IDX;
      else if (ev.weight == 0) rep.status = ST_ZERO_WT;
      else if (sh_reduced) rep.status = ST_REDUCED;
      else begin
         rep.status = ST_ADDED;
         addr = (sh_shared ? 0 : int'(ev.tid)) * BINS + int'(flat);
         neg  = ev.value[31];
         mag  = neg ? -ev.value : ev.value;
         prod = ev.weight * mag;
         wide = neg ? ({vsum_mem[addr][63], vsum_mem[addr]} - $signed({1'b0, prod}))
                    : ({vsum_mem[addr][63], vsum_mem[addr]} + $signed({1'b0, prod}));
         // clamp to the signed 64-bit range
         if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF)      vsum_mem[addr] = 64'h7FFF_FFFF_FFFF_FFFF;
         else if (wide < -65'sh0_8000_0000_0000_0000) vsum_mem[addr] = 64'h8000_0000_0000_0000;
         else vsum_mem[addr] = wide[63:0];
         wnext = wsum_mem[addr] + ev.weight;
         wsum_mem[addr] = wnext[WSUM_W] ? '1 : wnext[WSUM_W-1:0];
         if (hits_mem[addr] != '1) hits_mem[addr] = hits_mem[addr] + 1;
         rep.vsum = vsum_mem[addr];
         rep.wsum = wsum_mem[addr];
         rep.hits = hits_mem[addr];
      end
      return rep;
   endfunction

   // present one word, hold it until taken, then maybe idle
   task automatic send_word(tally_event_t ev);
      int gap;
      req_sample_value  <= ev.value;
      req_sample_weight <= ev.weight;
      req_thread_id     <= ev.tid;
      req_use_direct    <= ev.direct;
      req_flat_index_in <= ev.flat;
      req_bin_index0    <= ev.ix[0];
      req_bin_index1    <= ev.ix[1];
      req_bin_index2    <= ev.ix[2];
      req_bin_index3    <= ev.ix[3];
      req_push          <= 1'b1;
      do @(posedge clock); while (req_full);
      pending_reports.push_back(predict_bin(ev));
      gap = random_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(csr_reg_type idx, int data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_DIMS:    sh_dims    = data[2:0];
         REG_BINS0:   sh_bins[0] = data[CNT_W-1:0];
         REG_BINS1:   sh_bins[1] = data[CNT_W-1:0];
         REG_BINS2:   sh_bins[2] = data[CNT_W-1:0];
         REG_BINS3:   sh_bins[3] = data[CNT_W-1:0];
         REG_SIZE:    sh_size    = data[CNT_W-1:0];
         REG_SHARED:  sh_shared  = data[0];
         REG_REDUCED: sh_reduced = data[0];
      endcase
   endtask

   // drain: lower push, let every result come out, then cover latency
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_shape(int dims, int b0, int b1, int b2, int b3, int size,
                            int shared, int reduced);
      drain();
      write_reg(REG_DIMS, dims);
      write_reg(REG_BINS0, b0);
      write_reg(REG_BINS1, b1);
      write_reg(REG_BINS2, b2);
      write_reg(REG_BINS3, b3);
      write_reg(REG_SIZE, size);
      write_reg(REG_SHARED, shared);
      write_reg(REG_REDUCED, reduced);
   endtask

   function automatic tally_event_t make_event(logic [VAL_W-1:0] v, logic [WGT_W-1:0] w,
                                               int tid, int direct, int flat);
      tally_event_t ev;
      ev.value = v; ev.weight = w; ev.tid = tid; ev.direct = direct; ev.flat = flat;
      for (int d = 0; d < 4; d++) ev.ix[d] = '0;
      return ev;
   endfunction

   // mostly in-range addresses so bins fill up and collide; some noise
   function automatic tally_event_t random_event();
      tally_event_t ev;
      int r, usable;
      usable = (sh_size < BINS) ? sh_size : BINS;
      r = $urandom_range(0, 9);
      ev.value = (r == 0) ? 32'h7FFF_FFFF : (r == 1) ? 32'h8000_0000 : $urandom;
      r = $urandom_range(0, 19);
      ev.weight = (r == 0) ? 32'h0 : (r < 3) ? 32'hFFFF_FFFF :
                  (r < 10) ? $urandom_range(1, 32'h3_0000) : $urandom;
      ev.tid    = $urandom;
      ev.direct = ($urandom_range(0, 3) == 0);
      ev.flat   = ($urandom_range(0, 7) != 0 && usable > 0) ? $urandom_range(0, usable - 1)
                                                            : $urandom;
      for (int d = 0; d < 4; d++)
         ev.ix[d] = ($urandom_range(0, 9) != 0 && sh_bins[d] > 0)
                    ? $urandom_range(0, (sh_bins[d] > BINS ? BINS : sh_bins[d]) - 1)
                    : $urandom;
      return ev;
   endfunction

   // reset-time layout, direct addressing at both ends, all threads
   task automatic test_direct_extremes();
      send_word(make_event(32'h0001_0000, 32'h0001_0000, 0, 1, 0));
      send_word(make_event(32'hFFFF_0000, 32'h0000_0001, 3, 1, 1023));
      send_word(make_event(32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 512));
      send_word(make_event(32'h1234_5678, 32'h0002_0000, 2, 1, 0));
      send_word(make_event(32'h1234_5678, 32'h0002_0000, 2, 1, 0));
      send_word(make_event(32'h0001_0000, 32'h0001_0000, 0, 0, 0));
   endtask

   // value sum clamps both ways; error precedence
   task automatic test_saturation_and_errors();
      tally_event_t ev;
      for (int k = 0; k < 3; k++)
         send_word(make_event(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 7));
      for (int k = 0; k < 3; k++)
         send_word(make_event(32'h8000_0000, 32'hFFFF_FFFF, 2, 1, 9));
      send_word(make_event(32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 7));
      send_word(make_event(32'h0001_0000, 32'h0, 0, 1, 3));      // zero weight
      set_shape(2, 4, 8, 1, 1, 16, 0, 1);                         // reduced, small size
      send_word(make_event(32'h0001_0000, 32'h0, 0, 1, 20));     // bad index beats zero weight
      send_word(make_event(32'h0001_0000, 32'h0, 0, 1, 2));      // zero weight beats reduced
      send_word(make_event(32'h0001_0000, 32'h1, 0, 1, 2));      // reduced
      ev = make_event(32'h0001_0000, 32'h1, 0, 0, 0);
      ev.ix[0] = 3; ev.ix[1] = 1;                                 // radix 32 > size 16
      send_word(ev);
      ev.ix[0] = 5;                                               // index past its bin count
      send_word(ev);
   endtask

   task automatic run_random(int count);
      for (int k = 0; k < count; k++) send_word(random_event());
   endtask

   // walk the register space through its extremes
   task automatic test_random_shapes();
      set_shape(1, 1024, 1, 1, 1, 1024, 0, 0);  run_random(100);
      set_shape(2, 4, 8, 1, 1, 32, 0, 0);       run_random(110);
      set_shape(4, 2, 3, 2, 2, 24, 1, 0);       run_random(110);
      set_shape(3, 5, 5, 5, 1, 125, 0, 0);      run_random(100);
      set_shape(0, 16, 7, 7, 7, 16, 1, 0);      run_random(100);  // zero dims acts as one
      set_shape(7, 2, 2, 2, 2, 16, 0, 0);       run_random(100);  // over-range dims clamp
      set_shape(2, 1024, 1, 1, 1, 2047, 1, 0);  run_random(100);  // size capped
      set_shape(1, 3, 1, 1, 1, 1, 0, 0);        run_random(60);
      set_shape(2, 0, 2047, 1, 1, 1024, 0, 0);  run_random(60);   // zero bin count
      set_shape(4, 4, 4, 4, 4, 256, 0, 1);      run_random(60);
      set_shape(4, 32, 32, 1, 1, 1024, 1, 0);   run_random(100);
      set_shape(1, 1, 1, 1, 1, 1, 1, 0);        run_random(60);   // single bin, heavy reuse
   endtask

   // result checker and random pop stalls
   always @(posedge clock) begin
      bin_report_t want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("word with nothing pending", rsp_status, 0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_flat_index_out !== want.flat)
               report_mismatch("flat_index", rsp_flat_index_out, want.flat);
            if (rsp_value_sum !== want.vsum)
               report_mismatch("value_sum", rsp_value_sum, want.vsum);
            if (rsp_weight_sum !== want.wsum)
               report_mismatch("weight_sum", rsp_weight_sum, want.wsum);
            if (rsp_hit_count !== want.hits)
               report_mismatch("hit_count", rsp_hit_count, want.hits);
         end
      end
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else begin
         pop_hold <= random_gap();
         rsp_pop  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < DEPTH; k++) begin
         vsum_mem[k] = '0; wsum_mem[k] = '0; hits_mem[k] = '0;
      end
      sh_dims = 1; sh_bins[0] = 1024; sh_bins[1] = 1; sh_bins[2] = 1; sh_bins[3] = 1;
      sh_size = 1024; sh_shared = 1'b0; sh_reduced = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_direct_extremes();
      test_saturation_and_errors();
      test_random_shapes();
      drain();
      if (pending_reports.size() != 0 || fail_count != 0) begin
         $display("tb: failure");
      end else begin
         $display("tb: success");
      end
      $finish;
   end
endmodule

FILE: filelist.f
design/wta_pkg.sv
design/wta_front.sv
design/wta_queue.sv
design/wta_back.sv
design/weighted_tally_accumulator.sv
verif/weighted_tally_accumulator_tb.sv
